@@ rtl/tpa_pkg.sv @@
package tpa_pkg;

	localparam int PAGE_W = 10;
	localparam int KCNT_W = 9;
	localparam int UCNT_W = 10;

	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_FREE  = 2'd1;
	localparam logic [1:0] FUNC_COUNT = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OOM  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic              kern_sel;
		logic [PAGE_W-1:0] page_index;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [PAGE_W-1:0] alloc_index;
		logic [KCNT_W-1:0] kern_free_count;
		logic [UCNT_W-1:0] user_free_count;
	} rsp_t;

	typedef struct packed {
		logic rd;
		logic pop;
		logic push;
	} pool_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} pool_stat_t;

endpackage

@@ rtl/tpa_pool.sv @@
module tpa_pool #(
	parameter int DEPTH = 256,
	parameter int BASE = 0,
	localparam int MEM_DEPTH = (DEPTH < 2) ? 2 : DEPTH,
	localparam int AW = $clog2(MEM_DEPTH),
	localparam int CW = $clog2(DEPTH + 2)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tpa_pkg::pool_cmd_t         cmd,
	input  logic [tpa_pkg::PAGE_W-1:0] push_page,
	output tpa_pkg::pool_stat_t        stat,
	output logic [CW-1:0]              count,
	output logic [tpa_pkg::PAGE_W-1:0] pop_page
);
	import tpa_pkg::*;

	logic [PAGE_W-1:0] mem [MEM_DEPTH];
	logic [CW-1:0]     count_q;
	// Lowest count seen since reset. Entries below it were never pushed and
	// still hold their power-up page, so no clearing pass is needed.
	logic [CW-1:0]     low_q;
	logic [CW-1:0]     cnt_dec;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     addr_s1;
	logic              fresh_s1;
	logic [PAGE_W-1:0] rdata_s1;

	assign cnt_dec = count_q - CW'(1);
	assign rd_addr = cnt_dec[AW-1:0];
	assign wr_addr = count_q[AW-1:0];

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q >= CW'(DEPTH));
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= push_page;
		end
		if (cmd.rd) begin
			rdata_s1 <= mem[rd_addr];
			addr_s1  <= rd_addr;
			fresh_s1 <= (count_q == low_q);
		end
	end

	assign pop_page = fresh_s1 ? PAGE_W'(BASE + int'(addr_s1)) : rdata_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(DEPTH);
			low_q   <= CW'(DEPTH);
		end else if (cmd.pop) begin
			count_q <= cnt_dec;
			if (count_q == low_q) begin
				low_q <= cnt_dec;
			end
		end else if (cmd.push) begin
			count_q <= count_q + CW'(1);
		end
	end

`ifndef ASSERT_OFF
	a_low_mark: assert property (@(posedge clk) disable iff (!arst_n)
		low_q <= count_q)
		else $error("low-water mark above stack count");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q != '0) && $past(cmd.rd))
		else $error("pop without a prior read or on an empty stack");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (count_q < CW'(DEPTH)) && !cmd.pop)
		else $error("push into a full stack or together with pop");
`endif

endmodule

@@ rtl/two_pool_page_allocator_unit.sv @@
// A request accepted at a clock edge is registered in vld_s1 and req_s1; its
// result is then registered in status_q, index_q and done_q, and done pulses
// for exactly one cycle. No new request is taken while busy is high, as the
// stack memory that holds each pool's top entry is read ahead of each commit.
// Reset: both pools are full and start is taken from the first edge after reset
// is released; power-up stack contents come from a low-water mark, not a sweep.
module two_pool_page_allocator_unit #(
	parameter int TOTAL_PAGES = 1024,
	parameter int KERN_PAGES = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tpa_pkg::req_t req,
	output logic          done,
	output tpa_pkg::rsp_t rsp
);
	import tpa_pkg::*;

	localparam int KERN_DEPTH = (KERN_PAGES < TOTAL_PAGES) ? KERN_PAGES : TOTAL_PAGES;
	localparam int USER_DEPTH = TOTAL_PAGES - KERN_DEPTH;
	localparam int KCW = $clog2(KERN_DEPTH + 2);
	localparam int UCW = $clog2(USER_DEPTH + 2);

	logic              accept;
	logic              vld_s1;
	req_t              req_s1;
	pool_cmd_t         kern_cmd;
	pool_cmd_t         user_cmd;
	pool_stat_t        kern_stat;
	pool_stat_t        user_stat;
	pool_stat_t        sel_stat;
	logic [KCW-1:0]    kern_cnt;
	logic [UCW-1:0]    user_cnt;
	logic [PAGE_W-1:0] kern_page;
	logic [PAGE_W-1:0] user_page;
	logic              is_alloc;
	logic              is_free;
	logic              do_pop;
	logic              do_push;
	logic [1:0]        status_d;
	logic [1:0]        status_q;
	logic [PAGE_W-1:0] index_q;
	logic              done_q;

	assign busy   = vld_s1;
	assign accept = start && !vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= accept;
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// The top entry of the selected pool is read while the request is taken;
	// the pop or push commits in the following cycle, when the read data is back.
	assign is_alloc = (req_s1.func == FUNC_ALLOC);
	assign is_free  = (req_s1.func == FUNC_FREE);
	assign sel_stat = req_s1.kern_sel ? kern_stat : user_stat;
	assign do_pop   = vld_s1 && is_alloc && !sel_stat.empty;
	assign do_push  = vld_s1 && is_free && !sel_stat.full;

	assign kern_cmd.rd   = accept && req.kern_sel;
	assign kern_cmd.pop  = do_pop && req_s1.kern_sel;
	assign kern_cmd.push = do_push && req_s1.kern_sel;
	assign user_cmd.rd   = accept && !req.kern_sel;
	assign user_cmd.pop  = do_pop && !req_s1.kern_sel;
	assign user_cmd.push = do_push && !req_s1.kern_sel;

	tpa_pool #(
		.DEPTH (KERN_DEPTH),
		.BASE  (0)
	) u_kern_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (kern_cmd),
		.push_page (req_s1.page_index),
		.stat      (kern_stat),
		.count     (kern_cnt),
		.pop_page  (kern_page)
	);

	tpa_pool #(
		.DEPTH (USER_DEPTH),
		.BASE  (KERN_DEPTH)
	) u_user_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (user_cmd),
		.push_page (req_s1.page_index),
		.stat      (user_stat),
		.count     (user_cnt),
		.pop_page  (user_page)
	);

	always_comb begin
		status_d = ST_OK;
		if (is_alloc && sel_stat.empty) begin
			status_d = ST_OOM;
		end else if (is_free && sel_stat.full) begin
			status_d = ST_FULL;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			status_q <= status_d;
			if (do_pop) begin
				index_q <= req_s1.kern_sel ? kern_page : user_page;
			end else begin
				index_q <= '0;
			end
		end
	end

	// Counts only change at a commit edge, so during the result cycle they
	// already hold the values left by this request.
	assign done                = done_q;
	assign rsp.status          = status_q;
	assign rsp.alloc_index     = index_q;
	assign rsp.kern_free_count = KCNT_W'(kern_cnt);
	assign rsp.user_free_count = UCNT_W'(user_cnt);

`ifndef ASSERT_OFF
	a_two_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy ##1 (done && !busy))
		else $error("request did not complete in two cycles");

	a_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |=> $stable(kern_cnt) && $stable(user_cnt))
		else $error("free count changed without a request in flight");

	a_oom_index: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status != ST_OK) |-> (rsp.alloc_index == '0))
		else $error("failed request returned a page index");

	a_kern_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(kern_cnt <= KCW'(KERN_DEPTH)) && (user_cnt <= UCW'(USER_DEPTH)))
		else $error("pool count exceeds pool depth");
`endif

endmodule
